FILE: src/wbss_pkg.sv
// Shared constants and types for the wildcard byte signature scanner.
package wbss_pkg;

    localparam int MAX_PATTERN = 256;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int STEP_W      = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int GROUP       = 16;
    localparam int NUM_GROUPS  = (MAX_PATTERN + GROUP - 1) / GROUP;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_SCAN    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [7:0] REG_PATTERN_LENGTH = 8'd0;
    localparam logic [7:0] REG_REGION_BASE    = 8'd1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SCAN,
        OP_RESTART
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] idx;
        logic [7:0] value;
        logic       wild;
        logic [7:0] data;
        logic       last;
    } op_t;

    typedef enum logic {
        ST_RUN,
        ST_ALIGN
    } align_state_t;

endpackage

FILE: src/wbss_front.sv
// Input stage: accept words, classify them and drop those that do nothing.
module wbss_front
    import wbss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_index, entry_value, entry_wild, data_byte, zero pad
    input  logic [1:0]  s_tuser,   // mode
    input  logic        s_tlast,   // data_last
    output logic        op_valid,
    input  logic        op_ready,
    output op_t         op
);

    logic vld_reg;
    logic vld_next;
    op_t  op_reg;
    op_t  op_next;
    logic keep;
    logic accept;

    assign s_tready = !vld_reg || op_ready;
    assign accept   = s_tvalid && s_tready;
    assign op_valid = vld_reg;
    assign op       = op_reg;

    always_comb begin
        op_next.idx   = s_tdata[7:0];
        op_next.value = s_tdata[15:8];
        op_next.wild  = s_tdata[16];
        op_next.data  = s_tdata[24:17];
        op_next.last  = s_tlast;
        op_next.kind  = OP_SCAN;
        keep          = 1'b0;
        case (s_tuser)
            MODE_LOAD: begin
                op_next.kind = OP_LOAD;
                keep         = 32'(s_tdata[7:0]) < MAX_PATTERN;
            end
            MODE_SCAN: begin
                op_next.kind = OP_SCAN;
                keep         = 1'b1;
            end
            MODE_RESTART: begin
                op_next.kind = OP_RESTART;
                keep         = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        vld_next = vld_reg;
        if (op_ready) begin
            vld_next = 1'b0;
        end
        if (accept) begin
            vld_next = keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= op_next;
        end
    end

endmodule

FILE: src/wbss_fifo.sv
// Short queue of classified operations between the input and execution stages.
module wbss_fifo
    import wbss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  op_t  in_op,
    output logic out_valid,
    input  logic out_ready,
    output op_t  out_op
);

    op_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

FILE: src/wbss_back.sv
// Execution stage: signature store, window, compare pipeline and result register.
module wbss_back
    import wbss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  op_t         q_op,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // match_address
    output logic [0:0]  m_tuser    // found
);

    typedef struct packed {
        logic        vld;
        logic        restart;
        logic        last;
        logic        ge;
        logic [31:0] count;
    } s1_t;

    typedef struct packed {
        logic        vld;
        logic        restart;
        logic        last;
        logic        hit;
        logic [31:0] off;
    } s2_t;

    align_state_t state_reg;
    align_state_t state_next;
    logic         align_active;
    logic         run_active;

    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [31:0]            base_reg;
    logic [IDX_W-1:0]       first_reg;
    logic [IDX_W-1:0]       first_next;
    logic [IDX_W-1:0]       delta_reg;
    logic [IDX_W-1:0]       delta_next;
    logic [STEP_W-1:0]      step_reg;
    logic [MAX_PATTERN-1:0] mask_reg;
    logic [MAX_PATTERN-1:0] mask_next;
    logic [8:0]             plen_in;
    logic                   cfg_we;
    logic                   cfg_len_we;

    logic [7:0]             sig_val_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] sig_wild_reg;
    logic [7:0]             rot_val [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] rot_wild;
    logic                   align_shift;
    logic                   load_we;
    logic [IDX_W:0]         slot_sum;
    logic [IDX_W-1:0]       load_slot;

    logic [7:0]                   win_reg [MAX_PATTERN];
    logic [7:0]                   wshift [MAX_PATTERN];
    logic [NUM_GROUPS*GROUP-1:0]  eq_vec;
    logic [NUM_GROUPS-1:0]        grp_next;
    logic [NUM_GROUPS-1:0]        grp_reg;
    logic [31:0]                  count_reg;
    logic [31:0]                  count_next;

    logic advance;
    logic pop;
    s1_t  s1_reg;
    s1_t  s1_next;
    s2_t  s2_reg;
    s2_t  s2_next;

    logic        done_reg;
    logic        done_next;
    logic        res_valid;
    logic        res_found;
    logic [31:0] res_addr;
    logic        m_valid_reg;
    logic        m_found_reg;
    logic [31:0] m_addr_reg;

    // realignment sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN: begin
                if (cfg_len_we) begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (step_reg == STEP_W'(IDX_W - 1)) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb begin
        align_active = 1'b0;
        run_active   = 1'b0;
        case (state_reg)
            ST_RUN:   run_active   = 1'b1;
            ST_ALIGN: align_active = 1'b1;
            default:  run_active   = 1'b0;
        endcase
    end

    assign cfg_ready  = run_active;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign cfg_len_we = cfg_we && (cfg_index == REG_PATTERN_LENGTH);
    assign plen_in    = cfg_data[8:0];

    always_comb begin
        if (plen_in == '0) begin
            len_next = LEN_W'(1);
        end else if (32'(plen_in) > MAX_PATTERN) begin
            len_next = LEN_W'(MAX_PATTERN);
        end else begin
            len_next = LEN_W'(plen_in);
        end
        first_next = IDX_W'(LEN_W'(MAX_PATTERN) - len_next);
        if (first_next >= first_reg) begin
            delta_next = first_next - first_reg;
        end else begin
            delta_next = IDX_W'((IDX_W + 1)'(first_next) + (IDX_W + 1)'(MAX_PATTERN)
                                - (IDX_W + 1)'(first_reg));
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            mask_next[j] = IDX_W'(j) < first_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            len_reg   <= LEN_W'(1);
            base_reg  <= '0;
            first_reg <= IDX_W'(MAX_PATTERN - 1);
            delta_reg <= '0;
            step_reg  <= '0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                mask_reg[j] <= (j < MAX_PATTERN - 1);
            end
        end else begin
            state_reg <= state_next;
            if (cfg_len_we) begin
                len_reg   <= len_next;
                first_reg <= first_next;
                delta_reg <= delta_next;
                mask_reg  <= mask_next;
                step_reg  <= '0;
            end else if (align_active) begin
                step_reg <= step_reg + 1'b1;
            end
            if (cfg_we && (cfg_index == REG_REGION_BASE)) begin
                base_reg <= cfg_data;
            end
        end
    end

    // signature store, kept rotated so that entry k sits at slot k + first
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            rot_val[j]  = sig_val_reg[j];
            rot_wild[j] = sig_wild_reg[j];
            for (int s = 0; s < IDX_W; s++) begin
                if (step_reg == STEP_W'(s)) begin
                    rot_val[j]  = sig_val_reg[(j + MAX_PATTERN - ((1 << s) % MAX_PATTERN))
                                              % MAX_PATTERN];
                    rot_wild[j] = sig_wild_reg[(j + MAX_PATTERN - ((1 << s) % MAX_PATTERN))
                                               % MAX_PATTERN];
                end
            end
        end
    end

    assign align_shift = align_active && delta_reg[step_reg];
    assign advance     = !m_valid_reg || m_tready;
    assign q_ready     = run_active && advance;
    assign pop         = q_valid && q_ready;
    assign load_we     = pop && (q_op.kind == OP_LOAD);
    assign slot_sum    = (IDX_W + 1)'(q_op.idx) + (IDX_W + 1)'(first_reg);
    assign load_slot   = (slot_sum >= (IDX_W + 1)'(MAX_PATTERN))
                       ? IDX_W'(slot_sum - (IDX_W + 1)'(MAX_PATTERN)) : IDX_W'(slot_sum);

    always_ff @(posedge aclk) begin
        if (align_shift) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                sig_val_reg[j] <= rot_val[j];
            end
            sig_wild_reg <= rot_wild;
        end else if (load_we) begin
            sig_val_reg[load_slot]  <= q_op.value;
            sig_wild_reg[load_slot] <= q_op.wild;
        end
    end

    // window shift and per-byte compare
    always_comb begin
        for (int j = 0; j < MAX_PATTERN - 1; j++) begin
            wshift[j] = win_reg[j + 1];
        end
        wshift[MAX_PATTERN - 1] = q_op.data;
        eq_vec = '1;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            eq_vec[j] = mask_reg[j] || sig_wild_reg[j] || (wshift[j] == sig_val_reg[j]);
        end
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_next[g] = &eq_vec[g*GROUP +: GROUP];
        end
    end

    assign count_next = (count_reg == '1) ? count_reg : count_reg + 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                win_reg[j] <= '0;
            end
        end else if (pop && (q_op.kind == OP_RESTART)) begin
            count_reg <= '0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                win_reg[j] <= '0;
            end
        end else if (pop && (q_op.kind == OP_SCAN)) begin
            count_reg <= count_next;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                win_reg[j] <= wshift[j];
            end
        end
    end

    // compare pipeline
    always_comb begin
        s1_next.vld     = pop && ((q_op.kind == OP_SCAN) || (q_op.kind == OP_RESTART));
        s1_next.restart = q_op.kind == OP_RESTART;
        s1_next.last    = q_op.last;
        s1_next.ge      = count_next >= 32'(len_reg);
        s1_next.count   = count_next;

        s2_next.vld     = s1_reg.vld;
        s2_next.restart = s1_reg.restart;
        s2_next.last    = s1_reg.last;
        s2_next.hit     = s1_reg.ge && (&grp_reg);
        s2_next.off     = s1_reg.count - 32'(len_reg);
    end

    always_comb begin
        res_valid = 1'b0;
        res_found = 1'b0;
        res_addr  = '0;
        done_next = done_reg;
        if (s2_reg.vld) begin
            if (s2_reg.restart) begin
                done_next = 1'b0;
            end else if (!done_reg) begin
                if (s2_reg.hit) begin
                    res_valid = 1'b1;
                    res_found = 1'b1;
                    res_addr  = base_reg + s2_reg.off;
                    done_next = 1'b1;
                end else if (s2_reg.last) begin
                    res_valid = 1'b1;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg      <= '0;
            s2_reg      <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_reg      <= s1_next;
            s2_reg      <= s2_next;
            done_reg    <= done_next;
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            grp_reg     <= grp_next;
            m_found_reg <= res_found;
            m_addr_reg  <= res_addr;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_addr_reg;
    assign m_tuser[0] = m_found_reg;

endmodule

FILE: src/wildcard_byte_signature_scan.sv
// Top level of the wildcard byte signature scanner.
// A result word passes the input register, the queue, stages s1 and s2 and the output register.
// Throughput: one input word per cycle unless a rotation or output back-pressure stalls the back end.
// A pattern_length write starts a rotation of the signature store.
// Reset is synchronous, active low; it clears control, window and count, not the signature.
module wildcard_byte_signature_scan
    import wbss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_index, entry_value, entry_wild, data_byte, zero pad
    input  logic [1:0]  s_tuser,   // mode
    input  logic        s_tlast,   // data_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // match_address
    output logic [0:0]  m_tuser,   // found
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic front_valid;
    logic front_ready;
    op_t  front_op;
    logic q_valid;
    logic q_ready;
    op_t  q_op;

    wbss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .op_valid (front_valid),
        .op_ready (front_ready),
        .op       (front_op)
    );

    wbss_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_op     (front_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    wbss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_op      (q_op),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    a_no_pop_while_aligning: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_ready |-> !(q_valid && q_ready))
        else $error("queue popped during signature rotation");

    a_push_fills_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (front_valid && front_ready) |=> q_valid)
        else $error("queue empty after a push");

    a_length_write_aligns: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && (cfg_index == REG_PATTERN_LENGTH)) |=> !cfg_ready)
        else $error("pattern length write did not start rotation");
`endif

endmodule

FILE: verif/wildcard_byte_signature_scan_tb.sv
// Self-checking testbench for the wildcard byte signature scanner.
`timescale 1ns / 100ps

module wildcard_byte_signature_scan_tb;
    import wbss_pkg::*;

    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam int          SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          PHASE_WORDS   = 130;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] idx;
        logic [7:0] val;
        logic       wild;
        logic [7:0] dbyte;
        logic       is_last;
    } scan_word_t;

    typedef struct {
        logic        found;
        logic [31:0] addr;
    } scan_report_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    wildcard_byte_signature_scan u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scan_word_t   pending_words[$];
    scan_report_t expected_reports[$];
    scan_word_t   drv_word;
    int           words_in_flight = 0;
    int           words_queued    = 0;
    int           mismatch_count  = 0;
    int unsigned  cycle_count     = 0;
    int           send_idle_pct   = 0;
    int           recv_idle_pct   = 0;

    // scanner state as predicted
    logic [7:0]  model_window   [MAX_PATTERN];
    logic [7:0]  model_sig_byte [MAX_PATTERN];
    logic        model_sig_wild [MAX_PATTERN];
    logic [31:0] model_count;
    logic        model_done;
    logic [8:0]  model_len_reg;
    logic [31:0] model_base;

    // signature as the stimulus generator will have left it
    logic [7:0]  plan_sig_byte [MAX_PATTERN];
    logic        plan_sig_wild [MAX_PATTERN];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned effective_length(input logic [8:0] len_reg);
        if (len_reg == 0) return 1;
        if (len_reg > MAX_PATTERN) return MAX_PATTERN;
        return 32'(len_reg);
    endfunction

    function automatic void clear_scan_state();
        for (int i = 0; i < MAX_PATTERN; i++) model_window[i] = 8'h00;
        model_count = '0;
        model_done  = 1'b0;
    endfunction

    function automatic void predict_scan_word(input scan_word_t w);
        int unsigned  len;
        logic         hit;
        scan_report_t rep;
        case (w.mode)
            MODE_LOAD: begin
                model_sig_byte[w.idx] = w.val;
                model_sig_wild[w.idx] = w.wild;
            end
            MODE_RESTART: begin
                clear_scan_state();
            end
            MODE_SCAN: begin
                if (!model_done) begin
                    for (int i = 0; i < MAX_PATTERN - 1; i++) model_window[i] = model_window[i + 1];
                    model_window[MAX_PATTERN - 1] = w.dbyte;
                    if (model_count != 32'hFFFF_FFFF) model_count = model_count + 1;
                    len = effective_length(model_len_reg);
                    hit = (model_count >= len);
                    for (int k = 0; k < len; k++) begin
                        if (hit && !model_sig_wild[k]
                                && model_window[MAX_PATTERN - len + k] != model_sig_byte[k])
                            hit = 1'b0;
                    end
                    if (hit) begin
                        model_done = 1'b1;
                        rep.found  = 1'b1;
                        rep.addr   = model_base + (model_count - len);
                        expected_reports.push_back(rep);
                    end else if (w.is_last) begin
                        model_done = 1'b1;
                        rep.found  = 1'b0;
                        rep.addr   = '0;
                        expected_reports.push_back(rep);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_scan_word(drv_word);
                words_in_flight--;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, drv_word.dbyte, drv_word.wild, drv_word.val, drv_word.idx};
                    s_tuser  <= drv_word.mode;
                    s_tlast  <= drv_word.is_last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input scan_report_t exp_r);
        if (mismatch_count < 10)
            $display("%0t: %s: expected found=%0b addr=%08h, got found=%0b addr=%08h",
                     $realtime, what, exp_r.found, exp_r.addr, m_tuser[0], m_tdata);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : monitor
        scan_report_t exp_r;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                exp_r.found = 1'bx;
                exp_r.addr  = 'x;
                report_mismatch("unexpected word", exp_r);
            end else begin
                exp_r = expected_reports.pop_front();
                if (m_tuser[0] !== exp_r.found || m_tdata !== exp_r.addr)
                    report_mismatch("wrong word", exp_r);
            end
        end
    end

    function automatic scan_word_t rand_word(input logic [1:0] mode);
        scan_word_t w;
        w.mode    = mode;
        w.idx     = 8'($urandom_range(255));
        w.val     = 8'($urandom_range(255));
        w.wild    = 1'($urandom_range(1));
        w.dbyte   = 8'($urandom_range(255));
        w.is_last = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic void queue_word(input scan_word_t w);
        if (w.mode == MODE_LOAD) begin
            plan_sig_byte[w.idx] = w.val;
            plan_sig_wild[w.idx] = w.wild;
        end
        pending_words.push_back(w);
        words_in_flight++;
        words_queued++;
    endfunction

    function automatic void queue_load(input int idx, input logic [7:0] val, input logic wild);
        scan_word_t w;
        w      = rand_word(MODE_LOAD);
        w.idx  = 8'(idx);
        w.val  = val;
        w.wild = wild;
        queue_word(w);
    endfunction

    function automatic void queue_scan(input logic [7:0] dbyte, input logic is_last);
        scan_word_t w;
        w         = rand_word(MODE_SCAN);
        w.dbyte   = dbyte;
        w.is_last = is_last;
        queue_word(w);
    endfunction

    task automatic wait_drained();
        while (words_in_flight != 0 || expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (index == REG_PATTERN_LENGTH) model_len_reg = data[8:0];
        else if (index == REG_REGION_BASE) model_base = data;
        cfg_valid <= 1'b0;
    endtask

    // restart, optionally reload the signature, then one region that
    // mostly carries the signature somewhere inside
    task automatic queue_region(input int unsigned sig_len);
        int unsigned n;
        int unsigned pos;
        logic        embed;
        logic [7:0]  b;
        scan_word_t  w;
        queue_word(rand_word(MODE_RESTART));
        if (sig_len <= 24 && $urandom_range(1) == 1) begin
            for (int k = 0; k < sig_len; k++)
                queue_load(k, 8'($urandom_range(255)), $urandom_range(3) == 0);
        end
        if ($urandom_range(9) == 0) n = $urandom_range(sig_len, 1);
        else n = sig_len + $urandom_range(24);
        embed = ($urandom_range(3) != 0) && (n >= sig_len);
        pos   = (n >= sig_len) ? $urandom_range(n - sig_len) : 0;
        for (int i = 0; i < n; i++) begin
            if (embed && i >= pos && i < pos + sig_len)
                b = plan_sig_wild[i - pos] ? 8'($urandom_range(255)) : plan_sig_byte[i - pos];
            else if ($urandom_range(2) == 0)
                b = plan_sig_byte[$urandom_range(sig_len - 1)];
            else
                b = 8'($urandom_range(255));
            queue_scan(b, (i == n - 1) && ($urandom_range(9) != 0));
            if ($urandom_range(39) == 0) begin
                if (sig_len < MAX_PATTERN && $urandom_range(1) == 1) begin
                    w     = rand_word(MODE_LOAD);
                    w.idx = 8'($urandom_range(MAX_PATTERN - 1, sig_len));
                    queue_word(w);
                end else begin
                    queue_word(rand_word(MODE_UNUSED));
                end
            end
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) queue_word(rand_word(MODE_SCAN));
        end
    endtask

    task automatic run_phase(input logic [8:0] len_reg, input logic [31:0] base,
                             input int send_pct, input int recv_pct);
        int unsigned sig_len;
        logic        paused;
        wait_drained();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(REG_PATTERN_LENGTH, {23'd0, len_reg});
        write_reg(REG_REGION_BASE, base);
        sig_len      = effective_length(len_reg);
        words_queued = 0;
        paused       = 1'b0;
        while (words_queued < PHASE_WORDS) begin
            queue_region(sig_len);
            if (!paused && words_queued >= PHASE_WORDS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end
    endtask

    initial begin
        model_len_reg = 9'd1;
        model_base    = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            model_sig_byte[i] = 8'h00;
            model_sig_wild[i] = 1'b0;
        end
        clear_scan_state();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 57;

        // every signature entry gets written before any compare can see it
        for (int i = 0; i < MAX_PATTERN; i++)
            queue_load(i, 8'($urandom_range(255)), $urandom_range(3) == 0);
        wait_drained();

        write_reg(REG_PATTERN_LENGTH, 32'd3);
        write_reg(REG_REGION_BASE, 32'h0000_0100);
        queue_load(0, 8'hAA, 1'b0);
        queue_load(1, 8'h00, 1'b1);
        queue_load(2, 8'hFF, 1'b0);
        queue_load(255, 8'hFF, 1'b1);
        queue_word(rand_word(MODE_RESTART));
        queue_scan(8'h00, 1'b0);
        queue_scan(8'hAA, 1'b0);
        queue_scan(8'h55, 1'b0);
        queue_scan(8'hFF, 1'b0);
        queue_scan(8'hAA, 1'b1);
        queue_word(rand_word(MODE_UNUSED));
        queue_word(rand_word(MODE_RESTART));
        queue_scan(8'hAA, 1'b1);
        queue_word(rand_word(MODE_RESTART));
        queue_scan(8'h11, 1'b0);
        queue_scan(8'hAA, 1'b0);
        queue_scan(8'h00, 1'b0);
        queue_load(2, 8'h77, 1'b0);
        queue_scan(8'h77, 1'b1);
        queue_word(rand_word(MODE_RESTART));
        queue_scan(8'hFF, 1'b0);
        queue_scan(8'h00, 1'b0);
        queue_scan(8'h00, 1'b1);

        run_phase(9'd1,   32'h0000_0000, 28, 57);
        run_phase(9'd4,   32'hFFFF_FFFF, 28, 57);
        run_phase(9'd0,   $urandom,      28, 57);
        run_phase(9'd256, 32'hFFFF_FF80, 57, 28);
        run_phase(9'd8,   $urandom,      57, 28);
        run_phase(9'd300, $urandom,      57, 28);
        run_phase(9'd2,   $urandom,      0,  0);
        run_phase(9'd511, 32'hFFFF_FFF0, 0,  0);
        run_phase(9'd16,  $urandom,      0,  0);

        wait_drained();
        mismatch_count += expected_reports.size();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
